>>> src/d8_steepest_descent_direction_core_assert.svh
// ----------------------------------------------------------------------------
// d8 steepest descent direction core assertion macros
// shared property forms for the checker of the direction core
// ----------------------------------------------------------------------------
`ifndef D8_STEEPEST_DESCENT_DIRECTION_CORE_ASSERT_SVH
`define D8_STEEPEST_DESCENT_DIRECTION_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define D8_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define D8_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/d8sdd_pkg.sv
// ----------------------------------------------------------------------------
// d8sdd_pkg
// types and constants of the d8 steepest descent direction core
// ----------------------------------------------------------------------------
package d8sdd_pkg;

	localparam int ELEV_BITS  = 16;
	localparam int QBITS      = 16;
	localparam int SLOPE_BITS = ELEV_BITS + QBITS;
	localparam int NUM_DIRS   = 8;
	localparam int DIR_BITS   = 3;

	// 1/sqrt2 in q16
	localparam logic [QBITS-1:0] W_DIAG = 16'd46341;

	typedef struct packed {
		logic                 center_valid;
		logic [ELEV_BITS-1:0] center_elevation;
		logic [ELEV_BITS-1:0] elevation_n0;
		logic [ELEV_BITS-1:0] elevation_n1;
		logic [ELEV_BITS-1:0] elevation_n2;
		logic [ELEV_BITS-1:0] elevation_n3;
		logic [ELEV_BITS-1:0] elevation_n4;
		logic [ELEV_BITS-1:0] elevation_n5;
		logic [ELEV_BITS-1:0] elevation_n6;
		logic [ELEV_BITS-1:0] elevation_n7;
		logic [7:0]           neighbor_present;
		logic [7:0]           route_mask;
	} item_t;

	typedef struct packed {
		logic                has_direction;
		logic [DIR_BITS-1:0] direction;
		logic                chose_route;
	} result_t;

	// one lane's finding for one neighbor
	typedef struct packed {
		logic                  down;
		logic                  route;
		logic [SLOPE_BITS-1:0] slope;
	} lane_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

endpackage

>>> src/d8_steepest_descent_direction_core.sv
// ----------------------------------------------------------------------------
// d8_steepest_descent_direction_core
// d8 flow direction of one 3x3 elevation window per transfer
// ----------------------------------------------------------------------------
// One window is taken per clock while item_stall is low, and its result passes
// three register stages: the eight neighbor lanes form drops and q16-weighted
// slopes into the first, the merge tree reduces eight candidates to two into the
// second, and the final compare with the routing override fills the result
// register. Each stage moves on its own as soon as the stage after it is empty
// or moving, so a stalled result blocks input only once all three stages hold
// a window. The route_enable register is written over the cfg channel, which
// is always ready; write it only while no window is in flight.
module d8_steepest_descent_direction_core (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	// window channel
	input  logic                 item_valid,
	output logic                 item_stall,
	input  d8sdd_pkg::item_t     item,
	// direction channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output d8sdd_pkg::result_t   result
);
	import d8sdd_pkg::*;

	logic                 route_enable_q;
	logic                 vld_s1;
	logic                 vld_s2;
	logic                 vld_s3;
	adv_t                 adv;
	logic [ELEV_BITS-1:0] neigh [NUM_DIRS];
	lane_t [NUM_DIRS-1:0] lanes;

	// configuration: single register, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			route_enable_q <= cfg_data;
		end
	end

	// stage advance: a stage loads when empty or when its successor loads
	assign adv.s3     = !vld_s3 || !result_stall;
	assign adv.s2     = !vld_s2 || adv.s3;
	assign adv.s1     = !vld_s1 || adv.s2;
	assign item_stall = !adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv.s1) begin
				vld_s1 <= item_valid;
			end
			if (adv.s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv.s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// neighbor elevations in direction order
	assign neigh[0] = item.elevation_n0;
	assign neigh[1] = item.elevation_n1;
	assign neigh[2] = item.elevation_n2;
	assign neigh[3] = item.elevation_n3;
	assign neigh[4] = item.elevation_n4;
	assign neigh[5] = item.elevation_n5;
	assign neigh[6] = item.elevation_n6;
	assign neigh[7] = item.elevation_n7;

	// one lane per neighbor; odd directions are diagonal
	generate
		for (genvar i = 0; i < NUM_DIRS; i++) begin : g_lane
			d8sdd_lane #(
				.IS_DIAG ((i % 2) == 1)
			) u_lane (
				.clk          (clk),
				.en           (adv.s1),
				.center_valid (item.center_valid),
				.center       (item.center_elevation),
				.neighbor     (neigh[i]),
				.present      (item.neighbor_present[i]),
				.route_bit    (item.route_mask[i]),
				.route_enable (route_enable_q),
				.lane         (lanes[i])
			);
		end
	endgenerate

	// steepest and steepest-routing winners, result register
	d8sdd_merge u_merge (
		.clk    (clk),
		.adv    (adv),
		.lanes  (lanes),
		.result (result)
	);

	assign result_valid = vld_s3;

endmodule

>>> src/d8sdd_lane.sv
// ----------------------------------------------------------------------------
// d8sdd_lane
// drop and weighted slope toward one neighbor, registered
// ----------------------------------------------------------------------------
module d8sdd_lane #(
	parameter bit IS_DIAG = 1'b0
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic                                    center_valid,
	input  logic signed [d8sdd_pkg::ELEV_BITS-1:0] center,
	input  logic signed [d8sdd_pkg::ELEV_BITS-1:0] neighbor,
	input  logic                                    present,
	input  logic                                    route_bit,
	input  logic                                    route_enable,
	output d8sdd_pkg::lane_t                        lane
);
	import d8sdd_pkg::*;

	logic [ELEV_BITS:0]     dz;
	logic [ELEV_BITS-1:0]   mag;
	logic                   down;
	logic [SLOPE_BITS-1:0]  slope;
	lane_t                  lane_s1;

	// exact signed drop, one bit wider than the elevations
	assign dz   = {center[ELEV_BITS-1], center} - {neighbor[ELEV_BITS-1], neighbor};
	assign mag  = dz[ELEV_BITS-1:0];
	assign down = center_valid && present && !dz[ELEV_BITS] && (dz != '0);

	generate
		if (IS_DIAG) begin : g_diag
			assign slope = SLOPE_BITS'(mag) * SLOPE_BITS'(W_DIAG);
		end else begin : g_ortho
			assign slope = {mag, {QBITS{1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1.down  <= down;
			lane_s1.route <= down && route_enable && route_bit;
			lane_s1.slope <= slope;
		end
	end

	assign lane = lane_s1;

endmodule

>>> src/d8sdd_merge.sv
// ----------------------------------------------------------------------------
// d8sdd_merge
// two-stage max tree over the lanes, overall and routing winners
// ----------------------------------------------------------------------------
module d8sdd_merge (
	input  logic                                      clk,
	input  d8sdd_pkg::adv_t                           adv,
	input  d8sdd_pkg::lane_t [d8sdd_pkg::NUM_DIRS-1:0] lanes,
	output d8sdd_pkg::result_t                        result
);
	import d8sdd_pkg::*;

	typedef struct packed {
		logic                  found;
		logic [DIR_BITS-1:0]   idx;
		logic [SLOPE_BITS-1:0] slope;
	} best_t;

	best_t   leaf_b [NUM_DIRS];
	best_t   leaf_r [NUM_DIRS];
	best_t   lvl1_b [NUM_DIRS/2];
	best_t   lvl1_r [NUM_DIRS/2];
	best_t   pair_b_s2 [2];
	best_t   pair_r_s2 [2];
	best_t   fin_b;
	best_t   fin_r;
	result_t res_d;
	result_t result_s3;

	// a is the lower index side: b wins only when strictly steeper
	function automatic best_t pick(best_t a, best_t b);
		best_t r;
		if (b.found && (!a.found || (b.slope > a.slope))) begin
			r = b;
		end else begin
			r = a;
		end
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_DIRS; i++) begin
			leaf_b[i].found = lanes[i].down;
			leaf_b[i].idx   = DIR_BITS'(i);
			leaf_b[i].slope = lanes[i].slope;
			leaf_r[i].found = lanes[i].route;
			leaf_r[i].idx   = DIR_BITS'(i);
			leaf_r[i].slope = lanes[i].slope;
		end
		for (int j = 0; j < NUM_DIRS/2; j++) begin
			lvl1_b[j] = pick(leaf_b[2*j], leaf_b[2*j+1]);
			lvl1_r[j] = pick(leaf_r[2*j], leaf_r[2*j+1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int k = 0; k < 2; k++) begin
				pair_b_s2[k] <= pick(lvl1_b[2*k], lvl1_b[2*k+1]);
				pair_r_s2[k] <= pick(lvl1_r[2*k], lvl1_r[2*k+1]);
			end
		end
	end

	always_comb begin
		fin_b = pick(pair_b_s2[0], pair_b_s2[1]);
		fin_r = pick(pair_r_s2[0], pair_r_s2[1]);
		res_d = '0;
		if (fin_r.found) begin
			res_d.has_direction = 1'b1;
			res_d.direction     = fin_r.idx;
			res_d.chose_route   = 1'b1;
		end else if (fin_b.found) begin
			res_d.has_direction = 1'b1;
			res_d.direction     = fin_b.idx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			result_s3 <= res_d;
		end
	end

	assign result = result_s3;

endmodule

>>> src/d8sdd_checker.sv
// ----------------------------------------------------------------------------
// d8sdd_checker
// port-level checks of the direction core, bound to the top level
// ----------------------------------------------------------------------------
`include "d8_steepest_descent_direction_core_assert.svh"

module d8sdd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input d8sdd_pkg::result_t result
);
	import d8sdd_pkg::*;

	`D8_ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid, "stalled result dropped")
	`D8_ASSERT_NXT(a_res_stable, clk, arst_n, result_valid && result_stall, $stable(result), "stalled result changed")
	`D8_ASSERT_IMP(a_none_zero, clk, arst_n, result_valid && !result.has_direction, (result.direction == '0) && !result.chose_route, "no-direction result not zero")
	`D8_ASSERT_IMP(a_route_dir, clk, arst_n, result_valid && result.chose_route, result.has_direction, "route chosen without direction")
	`D8_ASSERT_IMP(a_in_stall, clk, arst_n, item_stall, result_valid && result_stall, "input stalled while output moves")

endmodule

bind d8_steepest_descent_direction_core d8sdd_checker u_d8sdd_checker (.*);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the d8 direction core against a behavioral slope predictor, with
// directed windows, randomized windows under both routing settings, bursty
// input and a receiver that stalls in shifting patterns
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import d8sdd_pkg::*;

	// q16 slope weights, orthogonal and diagonal (1/sqrt2)
	localparam longint ORTHO_Q16 = 65536;
	localparam longint DIAG_Q16  = 46341;
	// cycles without any transfer before the run is abandoned
	localparam int IDLE_LIMIT    = 3000;
	// pipeline depth plus margin
	localparam int SETTLE_CYCLES = 8;

	typedef logic [7:0][ELEV_BITS-1:0] ring_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_RUNS
	} stall_mode_e;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    cfg_valid    = 1'b0;
	logic    cfg_ready;
	logic    cfg_data     = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// testbench copy of the routing register
	logic        routing_on = 1'b0;
	// directions still owed by the core, oldest first
	result_t     pending_dirs[$];
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	int          burst_left     = 0;
	stall_mode_e stall_mode     = STALL_NONE;
	int          stall_left     = 0;
	int          stall_phase    = 0;

	d8_steepest_descent_direction_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// slope predictor: steepest positive drop, lowest index on ties,
	// steepest routing neighbor overrides when routing is on
	// ------------------------------------------------------------------
	function automatic result_t predict_direction(item_t w, logic routing);
		ring_t   ring;
		longint  drop;
		longint  slope;
		longint  best_slope;
		longint  route_slope;
		int      best_dir;
		int      route_dir;
		result_t r;
		ring = {w.elevation_n7, w.elevation_n6, w.elevation_n5, w.elevation_n4,
			w.elevation_n3, w.elevation_n2, w.elevation_n1, w.elevation_n0};
		r           = '0;
		best_dir    = -1;
		route_dir   = -1;
		best_slope  = 0;
		route_slope = 0;
		// no-data center never drains anywhere
		if (!w.center_valid)
			return r;
		for (int i = 0; i < 8; i++) begin
			if (!w.neighbor_present[i])
				continue;
			drop = longint'($signed(w.center_elevation)) - longint'($signed(ring[i]));
			if (drop <= 0)
				continue;
			slope = drop * ((i % 2) ? DIAG_Q16 : ORTHO_Q16);
			if (slope > best_slope) begin
				best_dir   = i;
				best_slope = slope;
			end
			if (routing && w.route_mask[i] && slope > route_slope) begin
				route_dir   = i;
				route_slope = slope;
			end
		end
		if (route_dir >= 0) begin
			r.has_direction = 1'b1;
			r.direction     = route_dir[2:0];
			r.chose_route   = 1'b1;
		end else if (best_dir >= 0) begin
			r.has_direction = 1'b1;
			r.direction     = best_dir[2:0];
		end
		return r;
	endfunction

	function automatic item_t pack_window(logic cv, logic [ELEV_BITS-1:0] c, ring_t ring,
		logic [7:0] present, logic [7:0] rmask);
		item_t w;
		w.center_valid     = cv;
		w.center_elevation = c;
		w.elevation_n0     = ring[0];
		w.elevation_n1     = ring[1];
		w.elevation_n2     = ring[2];
		w.elevation_n3     = ring[3];
		w.elevation_n4     = ring[4];
		w.elevation_n5     = ring[5];
		w.elevation_n6     = ring[6];
		w.elevation_n7     = ring[7];
		w.neighbor_present = present;
		w.route_mask       = rmask;
		return w;
	endfunction

	// random window: mostly neighbors clustered around the center so slopes
	// compete closely, plus raw noise, rail values and two-level ties
	function automatic item_t random_window();
		ring_t                ring;
		logic [ELEV_BITS-1:0] c;
		logic [ELEV_BITS-1:0] lo;
		logic [ELEV_BITS-1:0] hi;
		logic                 cv;
		logic [7:0]           present;
		logic [7:0]           rmask;
		int                   spread;
		int                   flavor;
		flavor = $urandom_range(0, 9);
		c      = 16'($urandom_range(0, 16'hFFFF));
		cv     = ($urandom_range(0, 15) != 0);
		case ($urandom_range(0, 2))
			0: spread = 3;
			1: spread = 40;
			default: spread = 2000;
		endcase
		lo = 16'($urandom_range(0, 16'hFFFF));
		hi = 16'($urandom_range(0, 16'hFFFF));
		for (int i = 0; i < 8; i++) begin
			if (flavor <= 5) begin
				ring[i] = 16'($signed(c) + $signed($urandom_range(0, 2 * spread)) - spread);
			end else if (flavor <= 7) begin
				ring[i] = 16'($urandom_range(0, 16'hFFFF));
			end else if (flavor == 8) begin
				case ($urandom_range(0, 3))
					0: ring[i] = 16'h8000;
					1: ring[i] = 16'h7FFF;
					2: ring[i] = 16'h0000;
					default: ring[i] = 16'hFFFF;
				endcase
			end else begin
				ring[i] = $urandom_range(0, 1) ? lo : hi;
			end
		end
		if (flavor == 8)
			c = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		if (flavor == 6 || flavor == 7)
			cv = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0, 1: present = 8'($urandom_range(0, 255));
			2: present = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'h55 << $urandom_range(0, 1);
			default: present = 8'hFF;
		endcase
		case ($urandom_range(0, 3))
			0: rmask = 8'h01 << $urandom_range(0, 7);
			1: rmask = 8'h00;
			default: rmask = 8'($urandom_range(0, 255));
		endcase
		return pack_window(cv, c, ring, present, rmask);
	endfunction

	// ------------------------------------------------------------------
	// monitors: register write, window intake, direction check
	// ------------------------------------------------------------------

	// routing setting follows each accepted register transfer
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			routing_on <= cfg_data;
	end

	// every accepted window owes exactly one direction
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			pending_dirs.push_back(predict_direction(item, routing_on));
	end

	// compare each direction transfer against the oldest owed one
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_dirs.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected direction transfer, expected none, actual %p",
					$time, result);
			end else begin
				want = pending_dirs.pop_front();
				if (result.has_direction !== want.has_direction) begin
					mismatch_count++;
					$display("%0t: has_direction mismatch, expected %0b, actual %0b",
						$time, want.has_direction, result.has_direction);
				end
				if (result.direction !== want.direction) begin
					mismatch_count++;
					$display("%0t: direction mismatch, expected %0d, actual %0d",
						$time, want.direction, result.direction);
				end
				if (result.chose_route !== want.chose_route) begin
					mismatch_count++;
					$display("%0t: chose_route mismatch, expected %0b, actual %0b",
						$time, want.chose_route, result.chose_route);
				end
			end
		end
	end

	// receiver: stall behavior switches, after a run of random length, between
	// never, coin flip, fixed duty pattern and long runs
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 150);
		end else begin
			stall_left--;
		end
		stall_phase = (stall_phase + 1) % 7;
		case (stall_mode)
			STALL_NONE:     result_stall <= 1'b0;
			STALL_COIN:     result_stall <= 1'($urandom_range(0, 1));
			STALL_PERIODIC: result_stall <= (stall_phase < 3);
			default:        result_stall <= ($urandom_range(0, 15) != 0) ? result_stall
				: ~result_stall;
		endcase
	end

	// watchdog on cycles where nothing at all transfers
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
			|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// hold one window until the core takes it; valid stays up afterwards
	task automatic send_window(item_t w);
		item       <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	// send inside bursts of random length with random gaps between them
	task automatic send_paced(item_t w);
		int gap;
		send_window(w);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 120)
				: $urandom_range(0, 12);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// sender goes quiet until every owed direction has arrived
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_dirs.size() != 0)
			@(posedge clk);
	endtask

	// register write only with the pipeline empty
	task automatic set_routing(logic en);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data  <= en;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// routing off: no-data center, flats, rails, ties, diagonal weighting
	task automatic test_plain_descent();
		ring_t ring;
		// no-data center with clear downhill all around
		send_window(pack_window(1'b0, 16'd100, {8{16'd0}}, 8'hFF, 8'h00));
		// flat, uphill, and all neighbors outside the grid
		send_window(pack_window(1'b1, 16'd7, {8{16'd7}}, 8'hFF, 8'h00));
		send_window(pack_window(1'b1, 16'd7, {8{16'd9}}, 8'hFF, 8'h00));
		send_window(pack_window(1'b1, 16'd7, {8{16'd0}}, 8'h00, 8'h00));
		// largest drop everywhere: orthogonal weight wins, then diagonals only
		send_window(pack_window(1'b1, 16'h7FFF, {8{16'h8000}}, 8'hFF, 8'h00));
		send_window(pack_window(1'b1, 16'h7FFF, {8{16'h8000}}, 8'hAA, 8'h00));
		// lowest possible center
		send_window(pack_window(1'b1, 16'h8000, {8{16'h7FFF}}, 8'hFF, 8'hFF));
		send_window(pack_window(1'b1, 16'h8000, {8{16'h8000}}, 8'hFF, 8'hFF));
		// equal orthogonal drops, lowest index wins
		ring = {8{16'd10}};
		ring[2] = 16'd5;
		ring[6] = 16'd5;
		send_window(pack_window(1'b1, 16'd10, ring, 8'hFF, 8'h00));
		// equal diagonal drops
		ring = {8{16'd10}};
		ring[3] = 16'd0;
		ring[7] = 16'd0;
		send_window(pack_window(1'b1, 16'd10, ring, 8'hFF, 8'h00));
		// diagonal drop 99 just beats orthogonal drop 70
		ring = {8{16'd100}};
		ring[0] = 16'd30;
		ring[1] = 16'd1;
		send_window(pack_window(1'b1, 16'd100, ring, 8'hFF, 8'h00));
		// diagonal drop 98 just loses to orthogonal drop 70
		ring[1] = 16'd2;
		send_window(pack_window(1'b1, 16'd100, ring, 8'hFF, 8'h00));
		// steepest neighbor lies outside the grid
		ring = {8{16'd0}};
		ring[4] = 16'h8AD0;
		ring[5] = 16'hFFFB;
		send_window(pack_window(1'b1, 16'd0, ring, 8'hEF, 8'h00));
		// route mask present but routing switched off
		ring = {8{16'd50}};
		ring[0] = 16'd0;
		ring[6] = 16'd40;
		send_window(pack_window(1'b1, 16'd50, ring, 8'hFF, 8'h40));
		wait_drained();
	endtask

	// routing on: override, fallback when the routed cell is not downhill
	task automatic test_route_override();
		ring_t ring;
		set_routing(1'b1);
		ring = {8{16'd50}};
		ring[0] = 16'd0;
		ring[6] = 16'd40;
		// shallow routed neighbor beats steep unrouted one
		send_window(pack_window(1'b1, 16'd50, ring, 8'hFF, 8'h40));
		// routed neighbor flat: plain steepest, no route flag
		send_window(pack_window(1'b1, 16'd50, ring, 8'hFF, 8'h02));
		// routed neighbor outside the grid
		send_window(pack_window(1'b1, 16'd50, ring, 8'hBF, 8'h40));
		// two routed neighbors with equal drop
		ring[2] = 16'd40;
		send_window(pack_window(1'b1, 16'd50, ring, 8'hFF, 8'h44));
		// routed neighbors but no-data center
		send_window(pack_window(1'b0, 16'd50, ring, 8'hFF, 8'hFF));
		// all routed at the rails, and nothing routed
		send_window(pack_window(1'b1, 16'h7FFF, {8{16'h8000}}, 8'hFF, 8'hFF));
		send_window(pack_window(1'b1, 16'd50, ring, 8'hFF, 8'h00));
		wait_drained();
	endtask

	// random windows under one routing setting, with one full drain mid-way
	task automatic test_random_windows(logic en, int count);
		int pause_at;
		set_routing(en);
		pause_at = $urandom_range(count / 4, 3 * count / 4);
		for (int n = 0; n < count; n++) begin
			if (n == pause_at)
				wait_drained();
			send_paced(random_window());
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		// reset held from time zero, then released on a clock edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_descent();
		test_route_override();
		test_random_windows(1'b0, 320);
		test_random_windows(1'b1, 320);
		test_random_windows(1'b0, 320);
		test_random_windows(1'b1, 320);

		// let the last directions come out, then a little extra
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
